@@ rtl/bgc_pkg.sv @@
package bgc_pkg;

  typedef enum logic [2:0] {
    ST_INACTIVE = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LONG     = 3'd2,
    ST_DOUBLE   = 3'd3,
    ST_DISABLED = 3'd4
  } status_t;

  localparam logic ACT_POLL   = 1'b0;
  localparam logic ACT_IGNORE = 1'b1;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [1:0] REG_DOUBLE_TAP    = 2'd1;
  localparam logic [1:0] REG_DISABLED_MASK = 2'd2;

  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] DOUBLE_TAP_RST = 16'd400;
  localparam logic [2:0]  DISABLED_RST   = 3'd0;

  typedef struct packed {
    logic        action;
    logic [1:0]  button;
    logic        pressed;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    status_t status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] double_tap_ms;
    logic [2:0]  disabled_mask;
  } cfg_t;

  typedef struct packed {
    logic held;
    logic ignored;
  } btn_flags_t;

endpackage

@@ rtl/bgc_stream_if.sv @@
interface bgc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bgc_cfg_regs.sv @@
module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_LONG_PRESS:    cfg_nxt.long_press_ms = pwdata[15:0];
        REG_DOUBLE_TAP:    cfg_nxt.double_tap_ms = pwdata[15:0];
        REG_DISABLED_MASK: cfg_nxt.disabled_mask = pwdata[2:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.double_tap_ms <= DOUBLE_TAP_RST;
      cfg_r.disabled_mask <= DISABLED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LONG_PRESS:    prdata = {16'd0, cfg_r.long_press_ms};
      REG_DOUBLE_TAP:    prdata = {16'd0, cfg_r.double_tap_ms};
      REG_DISABLED_MASK: prdata = {29'd0, cfg_r.disabled_mask};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bgc_classify.sv @@
module bgc_classify
  import bgc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  cfg_t                 cfg,
  input  in_item_t             item,
  input  logic                 in_range,
  input  btn_flags_t           flags,
  input  logic [TIME_BITS-1:0] press_start,
  input  logic [TIME_BITS-1:0] last_tap,
  output btn_flags_t           flags_new,
  output logic [TIME_BITS-1:0] press_start_new,
  output logic [TIME_BITS-1:0] last_tap_new,
  output logic                 wr_en,
  output status_t              status
);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since_start;
  logic [TIME_BITS-1:0] since_tap;
  logic [TIME_BITS-1:0] long_lim;
  logic [TIME_BITS-1:0] dbl_lim;
  logic [2:0]           mask_sh;
  logic                 tap_valid;
  logic                 disabled;

  assign now         = TIME_BITS'(item.now_ms);
  assign since_start = now - press_start;
  assign since_tap   = now - last_tap;
  assign long_lim    = TIME_BITS'(cfg.long_press_ms);
  assign dbl_lim     = TIME_BITS'(cfg.double_tap_ms);
  assign tap_valid   = (last_tap != '0);
  // buttons beyond the mask width shift to zero, so never disabled
  assign mask_sh     = cfg.disabled_mask >> item.button;
  assign disabled    = mask_sh[0];
  assign wr_en       = in_range;

  always_comb begin
    flags_new       = flags;
    press_start_new = press_start;
    last_tap_new    = last_tap;
    status          = ST_INACTIVE;
    priority if (!in_range) begin
      status = (item.action == ACT_POLL) ? ST_DISABLED : ST_INACTIVE;
    end else if (item.action == ACT_IGNORE) begin
      flags_new.ignored = 1'b1;
    end else if (disabled) begin
      status = ST_DISABLED;
    end else if (item.pressed) begin
      if (!flags.held) begin
        flags_new.held    = 1'b1;
        flags_new.ignored = 1'b0;
        press_start_new   = now;
      end else if (!flags.ignored && (since_start > long_lim)) begin
        status            = ST_LONG;
        flags_new.ignored = 1'b1;
      end
    end else if (flags.held) begin
      flags_new.held = 1'b0;
      if (!flags.ignored) begin
        if (tap_valid && (since_tap < dbl_lim)) begin
          last_tap_new = '0;
          status       = ST_DOUBLE;
        end else begin
          last_tap_new = now;
        end
      end
    end else if (tap_valid && (since_tap > dbl_lim)) begin
      // window ran out with no second tap
      last_tap_new = '0;
      status       = ST_SHORT;
    end
  end

endmodule

@@ rtl/button_gesture_classifier.sv @@
// each item passes an input register, then a result register
// one item per cycle unless stalled; state read-modify-write completes as the result registers
// a stalled result holds the input register, accepting again as soon as the result is taken
// reset: synchronous active-low rst_n clears all button state and loads register defaults
module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int NUM_BUTTONS = 3,
  parameter int TIME_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bgc_stream_if.sink            in_if,
  bgc_stream_if.source          out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t cfg;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_item_t s1_item_r;
  logic     res_valid_r;
  logic     res_valid_nxt;
  status_t  res_status_r;
  logic     advance;

  btn_flags_t           flags_r       [NUM_BUTTONS];
  logic [TIME_BITS-1:0] press_start_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0] last_tap_r    [NUM_BUTTONS];

  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  btn_flags_t           flags_new;
  logic [TIME_BITS-1:0] press_start_new;
  logic [TIME_BITS-1:0] last_tap_new;
  logic                 wr_en;
  status_t              status_new;

  bgc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register free or draining this cycle
  assign advance      = !res_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;
  assign s1_valid_nxt = (s1_valid_r && !advance) || (in_if.valid && in_if.ready);
  assign res_valid_nxt = (res_valid_r && !out_if.ready) || (s1_valid_r && advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.data;
    end
    if (s1_valid_r && advance) begin
      res_status_r <= status_new;
    end
  end

  assign in_range = (32'(s1_item_r.button) < 32'(NUM_BUTTONS));
  assign idx      = in_range ? IDX_W'(s1_item_r.button) : '0;

  bgc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .cfg             (cfg),
    .item            (s1_item_r),
    .in_range        (in_range),
    .flags           (flags_r[idx]),
    .press_start     (press_start_r[idx]),
    .last_tap        (last_tap_r[idx]),
    .flags_new       (flags_new),
    .press_start_new (press_start_new),
    .last_tap_new    (last_tap_new),
    .wr_en           (wr_en),
    .status          (status_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        flags_r[i]       <= '0;
        press_start_r[i] <= '0;
        last_tap_r[i]    <= '0;
      end
    end else if (s1_valid_r && advance && wr_en) begin
      flags_r[idx]       <= flags_new;
      press_start_r[idx] <= press_start_new;
      last_tap_r[idx]    <= last_tap_new;
    end
  end

  assign out_if.valid       = res_valid_r;
  assign out_if.data.status = res_status_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !res_valid_r |-> in_if.ready)
    else $error("input not ready while result register empty");

  a_stage_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_valid_r && !out_if.ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("pending item lost during result stall");

  a_long_sets_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && wr_en && status_new == ST_LONG) |=>
      flags_r[$past(idx)].ignored)
    else $error("long press left the press unignored");
`endif

endmodule
